// ----- hdl/arcb_pkg.sv -----
// shared constants and types of the arcball projection unit
`timescale 1ns / 1ps
package arcb_pkg;

    localparam int FRAC_BITS = 14;
    localparam int CFG_W     = 15;
    localparam int IDX_W     = 2;

    localparam logic [IDX_W-1:0] REG_WINDOW_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_WINDOW_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_HORIZ_ENABLE  = 2'd2;
    localparam logic [IDX_W-1:0] REG_VERT_ENABLE   = 2'd3;

    // mapping numerator and divisor with clamp flags
    typedef struct packed {
        logic        hi;
        logic        lo;
        logic [32:0] num;
        logic [15:0] den;
    } map_prep_t;

endpackage

// ----- hdl/arcb_div.sv -----
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module arcb_div #(
    parameter int NUM_W  = 33,
    parameter int DEN_W  = 16,
    parameter int Q_W    = 16,
    parameter int SIDE_W = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              ce,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side,
    output logic              out_valid,
    output logic [Q_W-1:0]    quo,
    output logic [SIDE_W-1:0] out_side
);

    logic [NUM_W-1:0]  rem_reg  [Q_W];
    logic [DEN_W-1:0]  den_reg  [Q_W];
    logic [Q_W-1:0]    quo_reg  [Q_W];
    logic [SIDE_W-1:0] side_reg [Q_W];
    logic [Q_W-1:0]    valid_reg;

    genvar i;
    for (i = 0; i < Q_W; i++)
    begin : g_stage
        logic [NUM_W-1:0]  rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [Q_W-1:0]    quo_in;
        logic [SIDE_W-1:0] side_in;
        logic              valid_in;
        logic [NUM_W-1:0]  shifted;
        logic              take;
        logic [NUM_W-1:0]  rem_next;
        logic [Q_W-1:0]    quo_next;

        if (i == 0)
        begin : g_first
            assign rem_in   = num;
            assign den_in   = den;
            assign quo_in   = '0;
            assign side_in  = side;
            assign valid_in = in_valid;
        end
        else
        begin : g_rest
            assign rem_in   = rem_reg[i-1];
            assign den_in   = den_reg[i-1];
            assign quo_in   = quo_reg[i-1];
            assign side_in  = side_reg[i-1];
            assign valid_in = valid_reg[i-1];
        end

        assign shifted  = NUM_W'(den_in) << (Q_W - 1 - i);
        assign take     = (rem_in >= shifted);
        assign rem_next = take ? (rem_in - shifted) : rem_in;
        assign quo_next = take ? (quo_in | (Q_W'(1) << (Q_W - 1 - i))) : quo_in;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (ce)
                valid_reg[i] <= valid_in;
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[i]  <= rem_next;
                den_reg[i]  <= den_in;
                quo_reg[i]  <= quo_next;
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign quo       = quo_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

// ----- hdl/arcb_sqrt.sv -----
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
module arcb_sqrt #(
    parameter int V_W    = 30,
    parameter int R_W    = 15,
    parameter int SIDE_W = 33
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              ce,
    input  logic              in_valid,
    input  logic [V_W-1:0]    val,
    input  logic [SIDE_W-1:0] side,
    output logic              out_valid,
    output logic [R_W-1:0]    root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int W = V_W + 1;

    logic [W-1:0]      rem_reg  [R_W];
    logic [R_W-1:0]    root_reg [R_W];
    logic [SIDE_W-1:0] side_reg [R_W];
    logic [R_W-1:0]    valid_reg;

    genvar i;
    for (i = 0; i < R_W; i++)
    begin : g_stage
        logic [W-1:0]      rem_in;
        logic [R_W-1:0]    root_in;
        logic [SIDE_W-1:0] side_in;
        logic              valid_in;
        logic [W-1:0]      trial;
        logic              take;
        logic [W-1:0]      rem_next;
        logic [R_W-1:0]    root_next;

        if (i == 0)
        begin : g_first
            assign rem_in   = W'(val);
            assign root_in  = '0;
            assign side_in  = side;
            assign valid_in = in_valid;
        end
        else
        begin : g_rest
            assign rem_in   = rem_reg[i-1];
            assign root_in  = root_reg[i-1];
            assign side_in  = side_reg[i-1];
            assign valid_in = valid_reg[i-1];
        end

        // (r + b)^2 - r^2 with b = 2^k
        assign trial     = (W'(root_in) << (R_W - i)) + (W'(1) << (2 * (R_W - 1 - i)));
        assign take      = (rem_in >= trial);
        assign rem_next  = take ? (rem_in - trial) : rem_in;
        assign root_next = take ? (root_in | (R_W'(1) << (R_W - 1 - i))) : root_in;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (ce)
                valid_reg[i] <= valid_in;
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[R_W-1];
    assign root      = root_reg[R_W-1];
    assign out_side  = side_reg[R_W-1];

endmodule

// ----- hdl/arcball_sphere_projection_unit.sv -----
// top level of the arcball projection unit
//
//  channel   direction  handshake               payload
//  input     in         in_valid / in_stall     cursor_x, cursor_y
//  output    out        out_valid / out_stall   sphere_x, sphere_y, sphere_z
//  config    in         cfg_wr_en               cfg_index, cfg_data
//
// one word per cycle sustained while out_stall does not hold a finished word
// pipeline depth comes mostly from the 16-bit mapping divider, the 15-bit square root and
// the 15-bit normalizing divider, each one bit per stage
// reset clears valid bits and loads the register defaults
// out_stall with a waiting word freezes the whole pipeline; nothing is lost
`timescale 1ns / 1ps
module arcball_sphere_projection_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [15:0]              cursor_x,
    input  logic signed [15:0]              cursor_y,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [15:0]              sphere_x,
    output logic signed [15:0]              sphere_y,
    output logic [14:0]                     sphere_z,
    input  logic                            cfg_wr_en,
    input  logic [arcb_pkg::IDX_W-1:0]      cfg_index,
    input  logic [arcb_pkg::CFG_W-1:0]      cfg_data
);
    import arcb_pkg::*;

    localparam int ONE = 1 << FRAC_BITS;

    // configuration registers
    logic [14:0] width_reg;
    logic [14:0] height_reg;
    logic        hen_reg;
    logic        ven_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 15'd1024;
            height_reg <= 15'd768;
            hen_reg    <= 1'b1;
            ven_reg    <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_WINDOW_WIDTH:  width_reg  <= cfg_data;
                REG_WINDOW_HEIGHT: height_reg <= cfg_data;
                REG_HORIZ_ENABLE:  hen_reg    <= cfg_data[0];
                REG_VERT_ENABLE:   ven_reg    <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // whole pipeline advances unless a finished word is held
    logic ce;
    assign in_stall = out_valid & out_stall;
    assign ce       = ~in_stall;

    // numerator (a*2^(F+1) + s), offset by ONE*2s so the quotient is nonnegative
    function automatic map_prep_t map_prep(input logic signed [17:0] a, input logic [14:0] s);
        logic signed [35:0] n;
        logic signed [35:0] s_sh;
        logic signed [35:0] lim_hi;
        logic signed [35:0] sum;
        map_prep_t          p;
        s_sh   = 36'(s) <<< (FRAC_BITS + 1);
        n      = (36'(a) <<< (FRAC_BITS + 1)) + 36'(s);
        lim_hi = s_sh + (36'(s) <<< 1);
        sum    = n + s_sh;
        p.hi   = (n >= lim_hi);
        p.lo   = (n < -s_sh);
        p.num  = sum[32:0];
        p.den  = {s, 1'b0};
        return p;
    endfunction

    // stage 1: mapping numerators
    logic [14:0]        sw;
    logic [14:0]        sh;
    logic signed [17:0] ax;
    logic signed [17:0] ay;
    map_prep_t          px_next, py_next, px_reg, py_reg;
    logic               s1_valid_reg;

    assign sw = (width_reg == 15'd0) ? 15'd1 : width_reg;
    assign sh = (height_reg == 15'd0) ? 15'd1 : height_reg;
    assign ax = (18'(cursor_x) <<< 1) - 18'($signed({1'b0, sw}));
    assign ay = 18'($signed({1'b0, sh})) - (18'(cursor_y) <<< 1);

    always_comb
    begin
        px_next = map_prep(ax, sw);
        py_next = map_prep(ay, sh);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (ce)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
    end

    // mapping dividers
    logic        dx_valid, dy_valid;
    logic [15:0] qx, qy;
    logic [1:0]  fx, fy;

    arcb_div #(.NUM_W(33), .DEN_W(16), .Q_W(16), .SIDE_W(2)) u_div_mx (
        .clk(clk), .rst_n(rst_n), .ce(ce), .in_valid(s1_valid_reg),
        .num(px_reg.num), .den(px_reg.den), .side({px_reg.hi, px_reg.lo}),
        .out_valid(dx_valid), .quo(qx), .out_side(fx)
    );

    arcb_div #(.NUM_W(33), .DEN_W(16), .Q_W(16), .SIDE_W(2)) u_div_my (
        .clk(clk), .rst_n(rst_n), .ce(ce), .in_valid(s1_valid_reg),
        .num(py_reg.num), .den(py_reg.den), .side({py_reg.hi, py_reg.lo}),
        .out_valid(dy_valid), .quo(qy), .out_side(fy)
    );

    // clamp and enable
    function automatic logic signed [15:0] clamp_axis(input logic [15:0] q,
                                                      input logic [1:0] f,
                                                      input logic en);
        logic signed [16:0] d;
        logic signed [15:0] r;
        d = $signed({1'b0, q}) - 17'(ONE);
        if (!en)
            r = '0;
        else if (f[1])
            r = 16'(ONE);
        else if (f[0])
            r = -16'(ONE);
        else
            r = d[15:0];
        return r;
    endfunction

    logic signed [15:0] x_reg, y_reg;
    logic               xy_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            xy_valid_reg <= 1'b0;
        else if (ce)
            xy_valid_reg <= dx_valid & dy_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            x_reg <= clamp_axis(qx, fx, hen_reg);
            y_reg <= clamp_axis(qy, fy, ven_reg);
        end
    end

    // squares
    logic signed [31:0] xsq, ysq;
    logic [28:0]        xx_reg, yy_reg;
    logic signed [15:0] x2_reg, y2_reg;
    logic               sq_valid_reg;

    assign xsq = x_reg * x_reg;
    assign ysq = y_reg * y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_valid_reg <= 1'b0;
        else if (ce)
            sq_valid_reg <= xy_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            xx_reg <= xsq[28:0];
            yy_reg <= ysq[28:0];
            x2_reg <= x_reg;
            y2_reg <= y_reg;
        end
    end

    // length squared, pick the radicand: inside disc takes ONE^2 - len2
    localparam logic [29:0] ONE_SQ = 30'(1) << (2 * FRAC_BITS);
    logic [29:0]        len2;
    logic               in_disc;
    logic [29:0]        rad_reg;
    logic [32:0]        sq_side_reg;
    logic               len_valid_reg;

    assign len2    = 30'(xx_reg) + 30'(yy_reg);
    assign in_disc = (len2 <= ONE_SQ);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_valid_reg <= 1'b0;
        else if (ce)
            len_valid_reg <= sq_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rad_reg     <= in_disc ? (ONE_SQ - len2) : len2;
            sq_side_reg <= {in_disc, x2_reg, y2_reg};
        end
    end

    logic        rt_valid;
    logic [14:0] rt;
    logic [32:0] rt_side;

    arcb_sqrt #(.V_W(30), .R_W(15), .SIDE_W(33)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .ce(ce), .in_valid(len_valid_reg),
        .val(rad_reg), .side(sq_side_reg),
        .out_valid(rt_valid), .root(rt), .out_side(rt_side)
    );

    // normalize setup: |c|*2^(F+1) + r over 2r
    logic               r_inside;
    logic signed [15:0] rx, ry;
    logic [14:0]        magx, magy;
    logic [29:0]        nx_reg, ny_reg;
    logic [15:0]        dn_reg;
    logic [47:0]        nm_side_reg;
    logic               ysign_reg;
    logic               nm_valid_reg;

    assign r_inside = rt_side[32];
    assign rx       = rt_side[31:16];
    assign ry       = rt_side[15:0];
    assign magx     = rx[15] ? 15'(-rx) : rx[14:0];
    assign magy     = ry[15] ? 15'(-ry) : ry[14:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nm_valid_reg <= 1'b0;
        else if (ce)
            nm_valid_reg <= rt_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            nx_reg      <= ({magx, 15'd0}) + 30'(rt);
            ny_reg      <= ({magy, 15'd0}) + 30'(rt);
            dn_reg      <= {rt, 1'b0};
            nm_side_reg <= {r_inside, rx, ry, rt};
            ysign_reg   <= ry[15];
        end
    end

    logic        ux_valid, uy_valid;
    logic [14:0] ux, uy;
    logic [47:0] u_side;
    logic        u_ysign;

    arcb_div #(.NUM_W(30), .DEN_W(16), .Q_W(15), .SIDE_W(48)) u_div_nx (
        .clk(clk), .rst_n(rst_n), .ce(ce), .in_valid(nm_valid_reg),
        .num(nx_reg), .den(dn_reg), .side(nm_side_reg),
        .out_valid(ux_valid), .quo(ux), .out_side(u_side)
    );

    arcb_div #(.NUM_W(30), .DEN_W(16), .Q_W(15), .SIDE_W(1)) u_div_ny (
        .clk(clk), .rst_n(rst_n), .ce(ce), .in_valid(nm_valid_reg),
        .num(ny_reg), .den(dn_reg), .side(ysign_reg),
        .out_valid(uy_valid), .quo(uy), .out_side(u_ysign)
    );

    // output word
    logic               f_inside;
    logic signed [15:0] fx_in, fy_in;
    logic [14:0]        fz_in;
    logic signed [15:0] sx_next, sy_next;
    logic [14:0]        sz_next;
    logic signed [15:0] sx_reg, sy_reg;
    logic [14:0]        sz_reg;
    logic               out_valid_reg;

    assign f_inside = u_side[47];
    assign fx_in    = u_side[46:31];
    assign fy_in    = u_side[30:15];
    assign fz_in    = u_side[14:0];

    always_comb
    begin
        if (f_inside)
        begin
            sx_next = fx_in;
            sy_next = fy_in;
            sz_next = fz_in;
        end
        else
        begin
            sx_next = fx_in[15] ? -$signed({1'b0, ux}) : $signed({1'b0, ux});
            sy_next = u_ysign ? -$signed({1'b0, uy}) : $signed({1'b0, uy});
            sz_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ce)
            out_valid_reg <= ux_valid & uy_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
            sz_reg <= sz_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign sphere_x  = sx_reg;
    assign sphere_y  = sy_reg;
    assign sphere_z  = sz_reg;

endmodule

// ----- tb/arcball_sphere_projection_unit_tb.sv -----
// self-checking testbench of the arcball projection unit
`timescale 1ns / 1ps
module arcball_sphere_projection_unit_tb;
    import arcb_pkg::*;

    localparam int ONE        = 1 << FRAC_BITS;
    localparam int LATENCY    = 52;
    localparam int N_RANDOM   = 1300;
    localparam int CYCLE_CAP  = 400000;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [15:0]        cursor_x;
    logic signed [15:0]        cursor_y;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [15:0]        sphere_x;
    logic signed [15:0]        sphere_y;
    logic [14:0]               sphere_z;
    logic                      cfg_wr_en;
    logic [IDX_W-1:0]          cfg_index;
    logic [CFG_W-1:0]          cfg_data;

    // one expected output word
    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic [14:0]        sz;
    } sphere_word_t;

    // directed row: cursor position, and optionally a typed-in answer
    typedef struct {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        bit                 known;
        sphere_word_t       ans;
    } cursor_row_t;

    sphere_word_t pending_points[$];

    // shadow copy of the register file
    logic [CFG_W-1:0] win_w;
    logic [CFG_W-1:0] win_h;
    logic             x_en;
    logic             y_en;

    int  send_idle_pct;
    int  recv_stall_pct;
    int  mismatches;
    int  words_checked;
    int  words_sent;
    longint cycle_count;

    arcball_sphere_projection_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cursor_x  (cursor_x),
        .cursor_y  (cursor_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sphere_x  (sphere_x),
        .sphere_y  (sphere_y),
        .sphere_z  (sphere_z),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // floor division for a positive divisor
    function automatic longint div_floor(longint n, longint d);
        if (n >= 0)
            return n / d;
        return -((-n + d - 1) / d);
    endfunction

    // bitwise integer square root, floor
    function automatic longint int_sqrt(longint v);
        longint res;
        longint b;
        res = 0;
        b = longint'(1) << 62;
        while (b > v)
            b = b >>> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v   = v - (res + b);
                res = (res >>> 1) + b;
            end
            else
                res = res >>> 1;
            b = b >>> 2;
        end
        return res;
    endfunction

    // pixel offset from window center as Q1.14, round half up, clamped
    function automatic longint pixel_to_unit(longint offs, longint size);
        longint q;
        q = div_floor(offs * 2 * ONE + size, 2 * size);
        if (q > ONE)
            q = ONE;
        if (q < -ONE)
            q = -ONE;
        return q;
    endfunction

    // coordinate times ONE over radius, rounded half away from zero
    function automatic longint to_unit_len(longint c, longint r);
        longint mag;
        longint q;
        mag = (c < 0) ? -c : c;
        q = (mag * ONE * 2 + r) / (2 * r);
        return (c < 0) ? -q : q;
    endfunction

    function automatic sphere_word_t project_cursor(logic signed [15:0] cx,
                                                    logic signed [15:0] cy);
        longint w;
        longint h;
        longint ux;
        longint uy;
        longint uz;
        longint len2;
        longint r;
        sphere_word_t pt;
        w = (win_w == 0) ? 1 : longint'(win_w);
        h = (win_h == 0) ? 1 : longint'(win_h);
        ux = x_en ? pixel_to_unit(2 * longint'(cx) - w, w) : 0;
        uy = y_en ? pixel_to_unit(h - 2 * longint'(cy), h) : 0;
        len2 = ux * ux + uy * uy;
        if (len2 <= longint'(ONE) * ONE)
            uz = int_sqrt(longint'(ONE) * ONE - len2);
        else
        begin
            // outside the disc: pull back onto the rim
            r  = int_sqrt(len2);
            ux = to_unit_len(ux, r);
            uy = to_unit_len(uy, r);
            uz = 0;
        end
        pt.sx = ux[15:0];
        pt.sy = uy[15:0];
        pt.sz = uz[14:0];
        return pt;
    endfunction

    // register write, only while the pipeline is empty
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_WINDOW_WIDTH:  win_w = val;
            REG_WINDOW_HEIGHT: win_h = val;
            REG_HORIZ_ENABLE:  x_en  = val[0];
            REG_VERT_ENABLE:   y_en  = val[0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // present one word, hold it until accepted; random idle beforehand
    task automatic send_cursor(logic signed [15:0] cx, logic signed [15:0] cy,
                               bit known, sphere_word_t ans);
        sphere_word_t pt;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        pt = project_cursor(cx, cy);
        if (known && pt !== ans)
            $display("note: typed answer for (%0d,%0d) differs from predictor", cx, cy);
        in_valid <= 1'b1;
        cursor_x <= cx;
        cursor_y <= cy;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // known rows use the typed-in answer as the expectation
        pending_points.push_back(known ? ans : pt);
        words_sent++;
    endtask

    // edge-biased random pixel coordinate
    function automatic logic signed [15:0] pick_pixel(logic [CFG_W-1:0] size);
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return 16'($urandom);
        if (sel == 1)
            return 16'(-$urandom_range(64));
        if (sel == 2)
            return 16'(size + $urandom_range(64));
        return 16'($urandom_range(size));
    endfunction

    task automatic random_phase(int count, int idle, int stall);
        sphere_word_t none;
        none = '0;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        repeat (count)
            send_cursor(pick_pixel(win_w), pick_pixel(win_h), 1'b0, none);
    endtask

    // output side: random stall, compare on every accepted word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_points.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word x=%0d y=%0d z=%0d",
                                 sphere_x, sphere_y, sphere_z);
                end
                else
                begin
                    sphere_word_t exp_pt;
                    exp_pt = pending_points.pop_front();
                    words_checked++;
                    if (sphere_x !== exp_pt.sx || sphere_y !== exp_pt.sy ||
                        sphere_z !== exp_pt.sz)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                                     exp_pt.sx, exp_pt.sy, exp_pt.sz,
                                     sphere_x, sphere_y, sphere_z);
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[arcball_sphere_projection_unit] ERROR");
            $finish;
        end
    end

    cursor_row_t directed_rows[$];

    function automatic cursor_row_t mk_row(int cx, int cy, bit known, int ex, int ey,
                                           int ez);
        cursor_row_t r;
        r.cx = 16'(cx);
        r.cy = 16'(cy);
        r.known = known;
        r.ans.sx = 16'(ex);
        r.ans.sy = 16'(ey);
        r.ans.sz = 15'(ez);
        return r;
    endfunction

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        cursor_x       = '0;
        cursor_y       = '0;
        out_stall      = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        mismatches     = 0;
        words_checked  = 0;
        words_sent     = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // reset defaults
        win_w = 1024;
        win_h = 768;
        x_en  = 1'b1;
        y_en  = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table under reset registers (1024 x 768)
        directed_rows.push_back(mk_row(512, 384, 1, 0, 0, ONE));       // window center
        directed_rows.push_back(mk_row(1024, 384, 1, ONE, 0, 0));      // right edge
        directed_rows.push_back(mk_row(0, 384, 1, -ONE, 0, 0));        // left edge
        directed_rows.push_back(mk_row(512, 0, 1, 0, ONE, 0));         // top edge
        directed_rows.push_back(mk_row(512, 768, 1, 0, -ONE, 0));      // bottom edge
        directed_rows.push_back(mk_row(32767, 384, 1, ONE, 0, 0));     // saturating right
        directed_rows.push_back(mk_row(-32768, 384, 1, -ONE, 0, 0));   // saturating left
        directed_rows.push_back(mk_row(512, 32767, 1, 0, -ONE, 0));    // saturating bottom
        directed_rows.push_back(mk_row(512, -32768, 1, 0, ONE, 0));    // saturating top
        directed_rows.push_back(mk_row(0, 0, 0, 0, 0, 0));             // corner, rim scaling
        directed_rows.push_back(mk_row(-32768, 32767, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(32767, -32768, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(-1, -1, 0, 0, 0, 0));           // all ones
        directed_rows.push_back(mk_row(700, 200, 0, 0, 0, 0));         // inside disc
        directed_rows.push_back(mk_row(513, 385, 0, 0, 0, 0));         // rounding tie region
        foreach (directed_rows[i])
            send_cursor(directed_rows[i].cx, directed_rows[i].cy,
                        directed_rows[i].known, directed_rows[i].ans);
        wait_drained();

        // zero-size windows count as one pixel; axes disabled
        write_reg(REG_WINDOW_WIDTH, 15'd0);
        write_reg(REG_WINDOW_HEIGHT, 15'd0);
        write_reg(REG_HORIZ_ENABLE, 15'd0);
        send_cursor(16'sd0, 16'sd0, 1'b0, '0);
        send_cursor(16'sd1, 16'sd1, 1'b0, '0);
        wait_drained();
        write_reg(REG_VERT_ENABLE, 15'd0);
        send_cursor(16'sd5, -16'sd5, 1'b1, '{sx: 16'sd0, sy: 16'sd0, sz: 15'(ONE)});
        wait_drained();
        write_reg(REG_HORIZ_ENABLE, 15'd1);
        write_reg(REG_VERT_ENABLE, 15'd1);
        send_cursor(16'sd0, 16'sd1, 1'b0, '0);
        wait_drained();

        // phase: reset-like geometry, no idling
        write_reg(REG_WINDOW_WIDTH, 15'd1024);
        write_reg(REG_WINDOW_HEIGHT, 15'd768);
        random_phase(N_RANDOM / 5, 0, 0);
        wait_drained();

        // phase: 16384-pixel window, sender idles half the time
        write_reg(REG_WINDOW_WIDTH, 15'd16384);
        write_reg(REG_WINDOW_HEIGHT, 15'd16384);
        random_phase(N_RANDOM / 5, 50, 0);
        // sender holds off until every word is back
        wait_drained();

        // phase: over-range register values, receiver stalls half the time
        write_reg(REG_WINDOW_WIDTH, 15'h7fff);
        write_reg(REG_WINDOW_HEIGHT, 15'd3);
        random_phase(N_RANDOM / 5, 0, 50);
        wait_drained();

        // phase: tiny windows, both sides idle a third of the time
        write_reg(REG_WINDOW_WIDTH, 15'd1);
        write_reg(REG_WINDOW_HEIGHT, 15'd2);
        random_phase(N_RANDOM / 10, 33, 33);
        wait_drained();

        // phase: random sizes and enables, mixed pressure
        repeat (6)
        begin
            write_reg(REG_WINDOW_WIDTH, 15'($urandom_range(1, 16384)));
            write_reg(REG_WINDOW_HEIGHT, 15'($urandom_range(1, 16384)));
            write_reg(REG_HORIZ_ENABLE,
                      15'($urandom_range(0, 1) | ($urandom_range(3) != 0)));
            write_reg(REG_VERT_ENABLE,
                      15'($urandom_range(0, 1) | ($urandom_range(3) != 0)));
            random_phase(N_RANDOM / 20, $urandom_range(2) * 33, $urandom_range(2) * 33);
            wait_drained();
        end

        recv_stall_pct = 0;
        repeat (LATENCY + 8) @(posedge clk);
        $display("run covered %0d cursor words, %0d results checked", words_sent,
                 words_checked);
        $display("window sizes from 1 to 32767 pixels, axis enables, four pressure modes");
        if (mismatches == 0 && pending_points.size() == 0)
            $display("[arcball_sphere_projection_unit] OK");
        else
        begin
            $display("%0d mismatches, %0d words missing", mismatches,
                     pending_points.size());
            $display("[arcball_sphere_projection_unit] ERROR");
        end
        $finish;
    end

endmodule
